/* rtl/ddwsc_pkg.sv */
`timescale 1ns / 1ps

package ddwsc_pkg;

  // Datapath widths
  localparam int ACC_W     = 51;  // widest lane product: (v -/+ hb*w) * inv_radius
  localparam int SUM_W     = 47;  // drive * 2^24 + gain * error
  localparam int DRV_W     = 9;   // signed PWM command
  localparam int REM_W     = 56;  // |sum| * 255 and divisor << 9
  localparam int QUO_W     = 10;  // quotient bits produced by the divider
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int PWM_MAX   = 255;

  // Register reset values
  localparam logic [15:0] HALF_BASELINE_RST = 16'd7537;
  localparam logic [15:0] INV_RADIUS_RST    = 16'd7273;
  localparam logic [23:0] VEL_PER_COUNT_RST = 24'd11438;
  localparam logic [11:0] LEFT_GAIN_RST     = 12'd128;
  localparam logic [11:0] RIGHT_GAIN_RST    = 12'd128;

  // Fixed-point constants
  localparam logic signed [ACC_W-1:0] ACC_S32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_S32_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] ACC_Q16_BIAS = ACC_W'(64'sd65535);
  localparam logic signed [ACC_W-1:0] ACC_ZERO     = ACC_W'(64'sd0);
  localparam logic signed [SUM_W-1:0] SUM_LIM      = SUM_W'(64'sd4278190080);
  localparam logic signed [SUM_W-1:0] SUM_Q24_BIAS = SUM_W'(64'sd16777215);
  localparam logic signed [SUM_W-1:0] SUM_ZERO     = SUM_W'(64'sd0);
  localparam logic signed [SUM_W-1:0] SUM_PWM_HI   = SUM_W'(PWM_MAX);
  localparam logic signed [SUM_W-1:0] SUM_PWM_LO   = SUM_W'(-PWM_MAX);

  typedef enum logic [1:0] {
    ACT_ENCODER = 2'd0,
    ACT_TWIST   = 2'd1,
    ACT_TICK    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_HALF_BASELINE = 3'd0,
    REG_INV_RADIUS    = 3'd1,
    REG_VEL_PER_COUNT = 3'd2,
    REG_LEFT_GAIN     = 3'd3,
    REG_RIGHT_GAIN    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] half_baseline;
    logic [15:0] inv_radius;
    logic [23:0] vel_per_count;
    logic [11:0] left_gain;
    logic [11:0] right_gain;
  } cfg_t;

  // One-hot step strobes shared by both wheel lanes
  typedef struct packed {
    logic enc_mul;
    logic enc_wr;
    logic tw_bw;
    logic tw_sum;
    logic tw_mul;
    logic tw_wr;
    logic tk_err;
    logic tk_mul;
    logic tk_sum;
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > ACC_S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < ACC_S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [DRV_W-1:0] clamp_pwm(input logic signed [SUM_W-1:0] x);
    logic signed [DRV_W-1:0] r;
    if (x > SUM_PWM_HI) begin
      r = DRV_W'(PWM_MAX);
    end else if (x < SUM_PWM_LO) begin
      r = DRV_W'(-PWM_MAX);
    end else begin
      r = $signed(x[DRV_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/ddwsc_if.sv */
`timescale 1ns / 1ps

interface ddwsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] linear_vel;
  logic signed [15:0] angular_vel;
  logic signed [15:0] left_delta;
  logic signed [15:0] right_delta;

  modport source (
    output valid, action, linear_vel, angular_vel, left_delta, right_delta,
    input  ready
  );
  modport sink (
    input  valid, action, linear_vel, angular_vel, left_delta, right_delta,
    output ready
  );
endinterface

interface ddwsc_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] left_pwm;
  logic signed [8:0] right_pwm;

  modport source (
    output valid, left_pwm, right_pwm,
    input  ready
  );
  modport sink (
    input  valid, left_pwm, right_pwm,
    output ready
  );
endinterface

/* rtl/ddwsc_cfg.sv */
`timescale 1ns / 1ps

module ddwsc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ddwsc_pkg::PADDR_W-1:0]   paddr,
  input  logic [ddwsc_pkg::PDATA_W-1:0]   pwdata,
  output logic [ddwsc_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  output ddwsc_pkg::cfg_t                 regs
);

  ddwsc_pkg::cfg_t regs_r;
  ddwsc_pkg::cfg_t regs_nxt;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[ddwsc_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        ddwsc_pkg::REG_HALF_BASELINE: regs_nxt.half_baseline = pwdata[15:0];
        ddwsc_pkg::REG_INV_RADIUS:    regs_nxt.inv_radius    = pwdata[15:0];
        ddwsc_pkg::REG_VEL_PER_COUNT: regs_nxt.vel_per_count = pwdata[23:0];
        ddwsc_pkg::REG_LEFT_GAIN:     regs_nxt.left_gain     = pwdata[11:0];
        ddwsc_pkg::REG_RIGHT_GAIN:    regs_nxt.right_gain    = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ddwsc_pkg::REG_HALF_BASELINE: prdata = ddwsc_pkg::PDATA_W'(regs_r.half_baseline);
      ddwsc_pkg::REG_INV_RADIUS:    prdata = ddwsc_pkg::PDATA_W'(regs_r.inv_radius);
      ddwsc_pkg::REG_VEL_PER_COUNT: prdata = ddwsc_pkg::PDATA_W'(regs_r.vel_per_count);
      ddwsc_pkg::REG_LEFT_GAIN:     prdata = ddwsc_pkg::PDATA_W'(regs_r.left_gain);
      ddwsc_pkg::REG_RIGHT_GAIN:    prdata = ddwsc_pkg::PDATA_W'(regs_r.right_gain);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.half_baseline <= ddwsc_pkg::HALF_BASELINE_RST;
      regs_r.inv_radius    <= ddwsc_pkg::INV_RADIUS_RST;
      regs_r.vel_per_count <= ddwsc_pkg::VEL_PER_COUNT_RST;
      regs_r.left_gain     <= ddwsc_pkg::LEFT_GAIN_RST;
      regs_r.right_gain    <= ddwsc_pkg::RIGHT_GAIN_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

/* rtl/ddwsc_lane.sv */
`timescale 1ns / 1ps

module ddwsc_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ddwsc_pkg::lane_ctl_t                  ctl,
  input  logic                                  side_right,
  input  logic [15:0]                           half_baseline,
  input  logic [15:0]                           inv_radius,
  input  logic [23:0]                           vel_per_count,
  input  logic [11:0]                           gain,
  input  logic signed [15:0]                    lin_vel,
  input  logic signed [15:0]                    ang_vel,
  input  logic signed [15:0]                    delta,
  input  logic                                  drive_wr,
  input  logic signed [ddwsc_pkg::DRV_W-1:0]    drive_in,
  output logic signed [ddwsc_pkg::SUM_W-1:0]    sum
);

  localparam int AW = ddwsc_pkg::ACC_W;
  localparam int SW = ddwsc_pkg::SUM_W;
  localparam int DW = ddwsc_pkg::DRV_W;

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [31:0]   target_r, target_nxt;
  logic signed [31:0]   measured_r, measured_nxt;
  logic signed [DW-1:0] drive_r;

  logic signed [40:0]   enc_prod;
  logic signed [32:0]   bw_prod;
  logic signed [33:0]   vv, bw_term, tw_sum;
  logic signed [AW-1:0] tw_prod;
  logic signed [AW-1:0] q16_bias, q16_biased, q16_trunc;
  logic signed [32:0]   err;
  logic signed [45:0]   gain_prod;
  logic signed [SW-1:0] drv_term, tk_sum;

  // encoder: counts * rad/s per count, Q.16
  assign enc_prod = 41'(delta) * 41'($signed({1'b0, vel_per_count}));

  // twist: v in Q8.24 -/+ half_baseline * w, then times 1/r
  assign bw_prod = 33'($signed({1'b0, half_baseline})) * 33'(ang_vel);
  assign vv      = 34'($signed({lin_vel, 16'h0000}));
  assign bw_term = 34'($signed(acc_r[32:0]));
  assign tw_sum  = side_right ? (vv + bw_term) : (vv - bw_term);
  assign tw_prod = 51'($signed(acc_r[33:0])) * 51'($signed({1'b0, inv_radius}));

  // divide by 2^16 toward zero
  assign q16_bias   = acc_r[AW-1] ? ddwsc_pkg::ACC_Q16_BIAS : ddwsc_pkg::ACC_ZERO;
  assign q16_biased = acc_r + q16_bias;
  assign q16_trunc  = q16_biased >>> 16;

  // tick: integral update in Q.24
  assign err       = 33'(target_r) - 33'(measured_r);
  assign gain_prod = 46'($signed({1'b0, gain})) * 46'($signed(acc_r[32:0]));
  assign drv_term  = SW'($signed({drive_r, 24'h000000}));
  assign tk_sum    = drv_term + SW'($signed(acc_r[45:0]));

  assign sum = $signed(acc_r[SW-1:0]);

  always_comb begin
    acc_nxt      = acc_r;
    target_nxt   = target_r;
    measured_nxt = measured_r;
    if (ctl.enc_mul) acc_nxt      = AW'(enc_prod);
    if (ctl.enc_wr)  measured_nxt = ddwsc_pkg::sat32(acc_r);
    if (ctl.tw_bw)   acc_nxt      = AW'(bw_prod);
    if (ctl.tw_sum)  acc_nxt      = AW'(tw_sum);
    if (ctl.tw_mul)  acc_nxt      = tw_prod;
    if (ctl.tw_wr)   target_nxt   = ddwsc_pkg::sat32(q16_trunc);
    if (ctl.tk_err)  acc_nxt      = AW'(err);
    if (ctl.tk_mul)  acc_nxt      = AW'(gain_prod);
    if (ctl.tk_sum)  acc_nxt      = AW'(tk_sum);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      measured_r <= '0;
      drive_r    <= '0;
    end else begin
      target_r   <= target_nxt;
      measured_r <= measured_nxt;
      if (drive_wr) begin
        drive_r <= drive_in;
      end
    end
  end

endmodule

/* rtl/ddwsc_div.sv */
`timescale 1ns / 1ps

module ddwsc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ddwsc_pkg::SUM_W-1:0]  dividend,
  input  logic [ddwsc_pkg::SUM_W-1:0]         divisor,
  output logic                                done,
  output logic signed [ddwsc_pkg::DRV_W-1:0]  quot
);

  localparam int SW = ddwsc_pkg::SUM_W;
  localparam int RW = ddwsc_pkg::REM_W;
  localparam int QW = ddwsc_pkg::QUO_W;
  localparam int DW = ddwsc_pkg::DRV_W;
  localparam int CW = ddwsc_pkg::CNT_W;

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] den_r, den_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;

  logic [SW-1:0] mag;
  logic [RW-1:0] mag_w;
  logic          ge;
  logic [DW-1:0] mag_q;

  assign mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
  assign mag_w = RW'(mag);
  assign ge    = rem_r >= den_r;

  // quotient of 256 or more saturates
  assign mag_q = (q_r > QW'(ddwsc_pkg::PWM_MAX)) ? DW'(ddwsc_pkg::PWM_MAX) : DW'(q_r);
  assign quot  = neg_r ? -$signed(mag_q) : $signed(mag_q);
  assign done  = done_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      // |dividend| * 255 over divisor, one quotient bit per cycle, MSB first
      rem_nxt = (mag_w << 8) - mag_w;
      den_nxt = RW'(divisor) << (QW - 1);
      q_nxt   = '0;
      neg_nxt = dividend[SW-1];
      cnt_nxt = CW'(ddwsc_pkg::DIV_STEPS - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? (rem_r - den_r) : rem_r;
      q_nxt   = {q_r[QW-2:0], ge};
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

/* rtl/ddwsc_merge.sv */
`timescale 1ns / 1ps

module ddwsc_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ddwsc_pkg::SUM_W-1:0]  sum_l,
  input  logic signed [ddwsc_pkg::SUM_W-1:0]  sum_r,
  output logic                                done,
  output logic signed [ddwsc_pkg::DRV_W-1:0]  pwm_l,
  output logic signed [ddwsc_pkg::DRV_W-1:0]  pwm_r
);

  localparam int SW = ddwsc_pkg::SUM_W;
  localparam int DW = ddwsc_pkg::DRV_W;

  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_GO_L  = 6'b000010,
    M_DIV_L = 6'b000100,
    M_GO_R  = 6'b001000,
    M_DIV_R = 6'b010000,
    M_DONE  = 6'b100000
  } mstate_t;

  mstate_t              state_r, state_nxt;
  logic [SW-1:0]        m_r, m_nxt;
  logic signed [DW-1:0] pwm_l_r, pwm_l_nxt;
  logic signed [DW-1:0] pwm_r_r, pwm_r_nxt;

  logic                 scale;
  logic signed [SW-1:0] larger;
  logic signed [SW-1:0] bias_l, bias_r, tr_l, tr_r;
  logic                 div_start;
  logic                 div_done;
  logic signed [SW-1:0] div_dividend;
  logic signed [DW-1:0] div_quot;

  assign scale  = (sum_l > ddwsc_pkg::SUM_LIM) || (sum_r > ddwsc_pkg::SUM_LIM);
  assign larger = (sum_l > sum_r) ? sum_l : sum_r;

  // unscaled path: divide by 2^24 toward zero
  assign bias_l = sum_l[SW-1] ? ddwsc_pkg::SUM_Q24_BIAS : ddwsc_pkg::SUM_ZERO;
  assign bias_r = sum_r[SW-1] ? ddwsc_pkg::SUM_Q24_BIAS : ddwsc_pkg::SUM_ZERO;
  assign tr_l   = (sum_l + bias_l) >>> 24;
  assign tr_r   = (sum_r + bias_r) >>> 24;

  assign div_start    = (state_r == M_GO_L) || (state_r == M_GO_R);
  assign div_dividend = (state_r == M_GO_R) ? sum_r : sum_l;

  ddwsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (m_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign done  = (state_r == M_DONE);
  assign pwm_l = pwm_l_r;
  assign pwm_r = pwm_r_r;

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    pwm_l_nxt = pwm_l_r;
    pwm_r_nxt = pwm_r_r;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          m_nxt     = SW'(larger);
          pwm_l_nxt = ddwsc_pkg::clamp_pwm(tr_l);
          pwm_r_nxt = ddwsc_pkg::clamp_pwm(tr_r);
          state_nxt = scale ? M_GO_L : M_DONE;
        end
      end
      M_GO_L: state_nxt = M_DIV_L;
      M_DIV_L: begin
        if (div_done) begin
          pwm_l_nxt = div_quot;
          state_nxt = M_GO_R;
        end
      end
      M_GO_R: state_nxt = M_DIV_R;
      M_DIV_R: begin
        if (div_done) begin
          pwm_r_nxt = div_quot;
          state_nxt = M_DONE;
        end
      end
      M_DONE:  state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    pwm_l_r <= pwm_l_nxt;
    pwm_r_r <= pwm_r_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/diff_drive_wheel_speed_controller.sv */
`timescale 1ns / 1ps

// Two-wheel speed controller for a differential-drive base. Each input word
// is one of three kinds: an encoder sample (left/right count deltas) sets the
// measured wheel speeds, a twist (linear and angular velocity, Q8.8) sets the
// target wheel speeds, and a control tick applies integral action to each
// wheel's PWM and returns one output word with both PWM commands (-255..255).
// If either updated PWM would exceed 255, both are scaled by 255 over the
// larger one. Encoder and twist words give no output word. Action code 3 is
// dropped. Parameters sit in five APB registers (byte addresses 0x0..0x10);
// write them only while the block is idle. Items run one at a time; when
// scaling applies, a tick also waits for the shared iterative divider,
// which runs 10 quotient steps for each wheel in turn. A finished tick
// result waits in the output register, so encoder and twist words keep
// flowing while the sink stalls; a second tick waits for that register.
module diff_drive_wheel_speed_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  ddwsc_in_if.sink                            in_if,
  ddwsc_out_if.source                         out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ddwsc_pkg::PADDR_W-1:0]       paddr,
  input  logic [ddwsc_pkg::PDATA_W-1:0]       pwdata,
  output logic [ddwsc_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  localparam int SW = ddwsc_pkg::SUM_W;
  localparam int DW = ddwsc_pkg::DRV_W;

  // One-hot sequencer, one state per lane step
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ENC_MUL  = 13'b0000000000010,
    S_ENC_WR   = 13'b0000000000100,
    S_TW_BW    = 13'b0000000001000,
    S_TW_SUM   = 13'b0000000010000,
    S_TW_MUL   = 13'b0000000100000,
    S_TW_WR    = 13'b0000001000000,
    S_TK_ERR   = 13'b0000010000000,
    S_TK_MUL   = 13'b0000100000000,
    S_TK_SUM   = 13'b0001000000000,
    S_MRG_GO   = 13'b0010000000000,
    S_MRG_WAIT = 13'b0100000000000,
    S_PUSH     = 13'b1000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic signed [15:0]   lin_r, ang_r, dl_r, dr_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_l_r, out_l_nxt;
  logic signed [DW-1:0] out_r_r, out_r_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic                 out_free;
  ddwsc_pkg::cfg_t      regs;
  ddwsc_pkg::lane_ctl_t lane_ctl;
  logic signed [SW-1:0] sum_l, sum_r;
  logic                 merge_start;
  logic                 merge_done;
  logic                 drive_wr;
  logic signed [DW-1:0] pwm_l, pwm_r;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign out_acc     = out_valid_r & out_if.ready;
  assign out_free    = ~out_valid_r | out_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.left_pwm  = out_l_r;
  assign out_if.right_pwm = out_r_r;

  // Register block
  ddwsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  // Step strobes decoded straight from the one-hot state
  always_comb begin
    lane_ctl.enc_mul = (state_r == S_ENC_MUL);
    lane_ctl.enc_wr  = (state_r == S_ENC_WR);
    lane_ctl.tw_bw   = (state_r == S_TW_BW);
    lane_ctl.tw_sum  = (state_r == S_TW_SUM);
    lane_ctl.tw_mul  = (state_r == S_TW_MUL);
    lane_ctl.tw_wr   = (state_r == S_TW_WR);
    lane_ctl.tk_err  = (state_r == S_TK_ERR);
    lane_ctl.tk_mul  = (state_r == S_TK_MUL);
    lane_ctl.tk_sum  = (state_r == S_TK_SUM);
  end

  // Drive state of both lanes is committed as soon as the merge finishes,
  // independent of when the output word is taken.
  assign merge_start = (state_r == S_MRG_GO);
  assign drive_wr    = (state_r == S_MRG_WAIT) & merge_done;

  // Left lane: target = (v - hb*w) / r
  ddwsc_lane u_lane_l (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (lane_ctl),
    .side_right    (1'b0),
    .half_baseline (regs.half_baseline),
    .inv_radius    (regs.inv_radius),
    .vel_per_count (regs.vel_per_count),
    .gain          (regs.left_gain),
    .lin_vel       (lin_r),
    .ang_vel       (ang_r),
    .delta         (dl_r),
    .drive_wr      (drive_wr),
    .drive_in      (pwm_l),
    .sum           (sum_l)
  );

  // Right lane: target = (v + hb*w) / r
  ddwsc_lane u_lane_r (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (lane_ctl),
    .side_right    (1'b1),
    .half_baseline (regs.half_baseline),
    .inv_radius    (regs.inv_radius),
    .vel_per_count (regs.vel_per_count),
    .gain          (regs.right_gain),
    .lin_vel       (lin_r),
    .ang_vel       (ang_r),
    .delta         (dr_r),
    .drive_wr      (drive_wr),
    .drive_in      (pwm_r),
    .sum           (sum_r)
  );

  // Merge: joint saturation of both wheel sums
  ddwsc_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (merge_start),
    .sum_l (sum_l),
    .sum_r (sum_r),
    .done  (merge_done),
    .pwm_l (pwm_l),
    .pwm_r (pwm_r)
  );

  // Hold the item fields for the lane steps
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lin_r <= in_if.linear_vel;
      ang_r <= in_if.angular_vel;
      dl_r  <= in_if.left_delta;
      dr_r  <= in_if.right_delta;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.action == ddwsc_pkg::ACT_ENCODER) begin
            state_nxt = S_ENC_MUL;
          end else if (in_if.action == ddwsc_pkg::ACT_TWIST) begin
            state_nxt = S_TW_BW;
          end else if (in_if.action == ddwsc_pkg::ACT_TICK) begin
            state_nxt = S_TK_ERR;
          end
        end
      end
      S_ENC_MUL:  state_nxt = S_ENC_WR;
      S_ENC_WR:   state_nxt = S_IDLE;
      S_TW_BW:    state_nxt = S_TW_SUM;
      S_TW_SUM:   state_nxt = S_TW_MUL;
      S_TW_MUL:   state_nxt = S_TW_WR;
      S_TW_WR:    state_nxt = S_IDLE;
      S_TK_ERR:   state_nxt = S_TK_MUL;
      S_TK_MUL:   state_nxt = S_TK_SUM;
      S_TK_SUM:   state_nxt = S_MRG_GO;
      S_MRG_GO:   state_nxt = S_MRG_WAIT;
      S_MRG_WAIT: begin
        if (merge_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // advance once the output register is empty or being emptied
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_l_nxt     = pwm_l;
          out_r_nxt     = pwm_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result word only ever comes out of the push step
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("output word raised outside the push step");

  // The merge only reports completion while the sequencer waits for it
  a_merge_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> (state_r == S_MRG_WAIT))
    else $error("merge completion outside the wait step");

  // A taken word with no reload leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && (state_r != S_PUSH)) |=> !out_valid_r)
    else $error("output word repeated after being taken");

  // Commands never leave the PWM range
  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_l_r != -9'sd256) && (out_r_r != -9'sd256))
    else $error("PWM command out of range");

endmodule
